>>> hw/rtl/detector_hit_router_macros.svh
// Assertion macros used by the hit router RTL.
`ifndef DETECTOR_HIT_ROUTER_MACROS_SVH
`define DETECTOR_HIT_ROUTER_MACROS_SVH

// Check on every clock edge outside reset.
`define DHR_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define DHR_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/dhr_pkg.sv
// Package: routing codes, channel bounds and list capacities of the hit router.
`default_nettype none

package dhr_pkg;

	localparam int RING_SLOTS   = 24;
	localparam int SECTOR_SLOTS = 8;
	localparam int LEAF_SLOTS   = 64;
	localparam int SHIELD_SLOTS = 16;

	localparam int CNT_W  = 7;
	localparam int SLOT_W = 6;
	localparam int NUM_LISTS = 16;

	typedef logic [CNT_W-1:0] cnt_t;

	// Destination codes; each code but DST_DROP also indexes its fill count.
	typedef enum logic [3:0] {
		DST_DROP       = 4'd0,
		DST_FRONT_RING = 4'd1,
		DST_FRONT_SECT = 4'd2,
		DST_THICK_RING = 4'd3,
		DST_THICK_SECT = 4'd4,
		DST_UP_RING    = 4'd5,
		DST_UP_SECT    = 4'd6,
		DST_LEAF_E     = 4'd7,
		DST_SHIELD_E   = 4'd8,
		DST_FRONT_RT   = 4'd9,
		DST_FRONT_ST   = 4'd10,
		DST_THICK_RT   = 4'd11,
		DST_THICK_ST   = 4'd12,
		DST_LEAF_T     = 4'd13,
		DST_SHIELD_T   = 4'd14,
		DST_UP_TIME    = 4'd15
	} dest_t;

	// Upstream summed time keeps two counts: ring in entry 15, sector in entry 0.
	localparam logic [3:0] UP_RING_T_CNT   = 4'd15;
	localparam logic [3:0] UP_SECTOR_T_CNT = 4'd0;

	localparam logic [7:0] KIND_ENERGY = 8'd1;
	localparam logic [7:0] KIND_TIME   = 8'd2;

	localparam logic [7:0] MOD_FRONT  = 8'd1;
	localparam logic [7:0] MOD_THICK  = 8'd2;
	localparam logic [7:0] MOD_UP     = 8'd3;
	localparam logic [7:0] MOD_LEAF_A = 8'd4;
	localparam logic [7:0] MOD_LEAF_B = 8'd5;
	localparam logic [7:0] MOD_SHIELD = 8'd6;

	localparam logic [15:0] CH_RING_END       = 16'd24;
	localparam logic [15:0] CH_LEAF_B_END     = 16'd16;
	localparam logic [15:0] CH_LEAF_B_OFS     = 16'd32;
	localparam logic [15:0] CH_SHIELD_E_END   = 16'd12;
	localparam logic [15:0] CH_T_FRONT_SECT   = 16'd24;
	localparam logic [15:0] CH_T_THICK_RING   = 16'd32;
	localparam logic [15:0] CH_T_THICK_SECT   = 16'd56;
	localparam logic [15:0] CH_T_LEAF         = 16'd64;
	localparam logic [15:0] CH_T_SHIELD       = 16'd112;
	localparam logic [15:0] CH_T_SHIELD_END   = 16'd124;
	localparam logic [15:0] CH_T_UP_SUM       = 16'd127;

	localparam logic [7:0] REG_DE_THR   = 8'd0;
	localparam logic [7:0] REG_E1_THR   = 8'd1;
	localparam logic [7:0] REG_UP_THR   = 8'd2;
	localparam logic [7:0] REG_TIME_OVF = 8'd3;

	localparam logic [15:0] DE_THR_RST   = 16'd10;
	localparam logic [15:0] E1_THR_RST   = 16'd10;
	localparam logic [15:0] UP_THR_RST   = 16'd10;
	localparam logic [15:0] TIME_OVF_RST = 16'd7680;

	function automatic cnt_t cap_of(input dest_t d);
		cnt_t cap;
		unique case (d)
			DST_FRONT_RING, DST_THICK_RING, DST_UP_RING,
			DST_FRONT_RT, DST_THICK_RT:        cap = CNT_W'(RING_SLOTS);
			DST_FRONT_SECT, DST_THICK_SECT, DST_UP_SECT,
			DST_FRONT_ST, DST_THICK_ST:        cap = CNT_W'(SECTOR_SLOTS);
			DST_LEAF_E, DST_LEAF_T:            cap = CNT_W'(LEAF_SLOTS);
			DST_SHIELD_E, DST_SHIELD_T:        cap = CNT_W'(SHIELD_SLOTS);
			default:                           cap = '0;
		endcase
		return cap;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/detector_hit_router.sv
// Top level: routes readout hits into per-detector lists with fill counts.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------------
//  hit      | hit_valid / hit_stall    | event_start, hit_kind, module_id,
//           |                          | channel_number, sample_value
//  result   | res_valid / res_stall    | destination, slot_index, detector_channel,
//           |                          | passed_value
//  cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
//  One word per cycle sustained while res_stall is low; each word passes the input register,
//  then the result register, before its result is offered.
//  The 16-entry fill-count read-modify-write between the two registers sets the rate:
//  a word sees the counts its predecessor left.
//  Reset clears the thresholds to their defaults, all fill counts and both valid flags.
//  A stalled result register holds the input register, and hit_stall rises only then.
//  cfg_ready is always high; configuration writes are registered.
`default_nettype none

`include "detector_hit_router_macros.svh"

module detector_hit_router
	import dhr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// hit words
	input  wire logic               hit_valid,
	output logic                    hit_stall,
	input  wire logic               event_start,
	input  wire logic [7:0]         hit_kind,
	input  wire logic [7:0]         module_id,
	input  wire logic [15:0]        channel_number,
	input  wire logic signed [31:0] sample_value,
	// result words
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [3:0]              destination,
	output logic [SLOT_W-1:0]       slot_index,
	output logic [15:0]             detector_channel,
	output logic signed [31:0]      passed_value,
	// configuration writes
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [7:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);

	// Configuration registers.
	logic [15:0] de_thr_q, e1_thr_q, up_thr_q, time_ovf_q;

	// Input register stage.
	logic               valid_s1;
	logic               evt_s1;
	logic [7:0]         kind_s1;
	logic [7:0]         mod_s1;
	logic [15:0]        ch_s1;
	logic signed [31:0] val_s1;

	// Result register stage.
	logic               valid_s2;
	dest_t              dest_s2;
	logic [SLOT_W-1:0]  slot_s2;
	logic [15:0]        chan_s2;
	logic signed [31:0] value_s2;

	cnt_t cnt_q   [NUM_LISTS];
	cnt_t cnt_eff [NUM_LISTS];
	cnt_t cnt_nxt [NUM_LISTS];

	logic        adv_s1;
	dest_t       route;
	logic [15:0] route_ch;
	dest_t       dest;
	logic [15:0] dch;
	logic [SLOT_W-1:0] slot;
	cnt_t        cnt_sel;
	logic        push_ok;
	logic        up_ring_ok, up_sect_ok;
	logic        e_pass_front, e_pass_thick, e_pass_up;
	logic        t_in_range;

	// Advance the input register whenever the result register is free or draining.
	assign adv_s1    = !valid_s2 || !res_stall;
	assign hit_stall = valid_s1 && !adv_s1;
	assign cfg_ready = 1'b1;

	// --------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			de_thr_q   <= DE_THR_RST;
			e1_thr_q   <= E1_THR_RST;
			up_thr_q   <= UP_THR_RST;
			time_ovf_q <= TIME_OVF_RST;
		end else if (cfg_valid && cfg_ready) begin
			// Writes beyond the register list are ignored.
			if (cfg_index == REG_DE_THR)   de_thr_q   <= cfg_data;
			if (cfg_index == REG_E1_THR)   e1_thr_q   <= cfg_data;
			if (cfg_index == REG_UP_THR)   up_thr_q   <= cfg_data;
			if (cfg_index == REG_TIME_OVF) time_ovf_q <= cfg_data;
		end
	end

	// -------------------------------------------------------- input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hit_stall) begin
			valid_s1 <= hit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hit_stall && hit_valid) begin
			evt_s1  <= event_start;
			kind_s1 <= hit_kind;
			mod_s1  <= module_id;
			ch_s1   <= channel_number;
			val_s1  <= sample_value;
		end
	end

	// -------------------------------------------------------------- routing
	// Thresholds: a negative value never passes, since the register is zero-extended.
	assign e_pass_front = val_s1 > $signed({16'd0, de_thr_q});
	assign e_pass_thick = val_s1 > $signed({16'd0, e1_thr_q});
	assign e_pass_up    = val_s1 > $signed({16'd0, up_thr_q});
	// Negative times always pass the overflow cut.
	assign t_in_range   = val_s1 < $signed({16'd0, time_ovf_q});

	always_comb begin
		route    = DST_DROP;
		route_ch = '0;
		if (kind_s1 == KIND_ENERGY) begin
			priority if ((mod_s1 == MOD_FRONT && e_pass_front) ||
			             (mod_s1 == MOD_THICK && e_pass_thick) ||
			             (mod_s1 == MOD_UP && e_pass_up)) begin
				// Ring below channel 24, sector from 24 up (channel less the offset).
				if (ch_s1 < CH_RING_END) begin
					route    = (mod_s1 == MOD_FRONT) ? DST_FRONT_RING :
					           (mod_s1 == MOD_THICK) ? DST_THICK_RING : DST_UP_RING;
					route_ch = ch_s1;
				end else begin
					route    = (mod_s1 == MOD_FRONT) ? DST_FRONT_SECT :
					           (mod_s1 == MOD_THICK) ? DST_THICK_SECT : DST_UP_SECT;
					route_ch = ch_s1 - CH_RING_END;
				end
			end else if (mod_s1 == MOD_LEAF_A) begin
				route    = DST_LEAF_E;
				route_ch = ch_s1;
			end else if (mod_s1 == MOD_LEAF_B && ch_s1 < CH_LEAF_B_END) begin
				route    = DST_LEAF_E;
				route_ch = ch_s1 + CH_LEAF_B_OFS;
			end else if (mod_s1 == MOD_SHIELD && ch_s1 < CH_SHIELD_E_END) begin
				route    = DST_SHIELD_E;
				route_ch = ch_s1;
			end else begin
				// Unknown module, energy below threshold or channel out of range: leave unmapped.
				route    = DST_DROP;
			end
		end else if (kind_s1 == KIND_TIME && t_in_range) begin
			priority if (ch_s1 < CH_T_FRONT_SECT) begin
				route    = DST_FRONT_RT;
				route_ch = ch_s1;
			end else if (ch_s1 < CH_T_THICK_RING) begin
				route    = DST_FRONT_ST;
				route_ch = ch_s1 - CH_T_FRONT_SECT;
			end else if (ch_s1 < CH_T_THICK_SECT) begin
				route    = DST_THICK_RT;
				route_ch = ch_s1 - CH_T_THICK_RING;
			end else if (ch_s1 < CH_T_LEAF) begin
				route    = DST_THICK_ST;
				route_ch = ch_s1 - CH_T_THICK_SECT;
			end else if (ch_s1 < CH_T_SHIELD) begin
				route    = DST_LEAF_T;
				route_ch = ch_s1 - CH_T_LEAF;
			end else if (ch_s1 < CH_T_SHIELD_END) begin
				route    = DST_SHIELD_T;
				route_ch = ch_s1 - CH_T_SHIELD;
			end else if (ch_s1 == CH_T_UP_SUM) begin
				route    = DST_UP_TIME;
				route_ch = '0;
			end else begin
				// Spare channels between the shield range and the summed time, and above it.
				route    = DST_DROP;
			end
		end
	end

	// --------------------------------------------------------- fill counts
	// Event start clears every count before this word is routed.
	always_comb begin
		for (int i = 0; i < NUM_LISTS; i++) begin
			cnt_eff[i] = evt_s1 ? '0 : cnt_q[i];
		end
	end

	assign cnt_sel    = cnt_eff[route];
	assign push_ok    = cnt_sel < cap_of(route);
	assign up_ring_ok = cnt_eff[UP_RING_T_CNT] < CNT_W'(RING_SLOTS);
	assign up_sect_ok = cnt_eff[UP_SECTOR_T_CNT] < CNT_W'(SECTOR_SLOTS);

	always_comb begin
		dest = route;
		dch  = route_ch;
		slot = cnt_sel[SLOT_W-1:0];
		if (route == DST_UP_TIME) begin
			// Summed time reports the ring time count from before this word.
			slot = cnt_eff[UP_RING_T_CNT][SLOT_W-1:0];
			if (!up_ring_ok && !up_sect_ok) begin
				dest = DST_DROP;
			end
		end else if (route != DST_DROP && !push_ok) begin
			// Full list: drop, never spill a ring hit into the sector list.
			dest = DST_DROP;
		end
		if (dest == DST_DROP) begin
			dch  = '0;
			slot = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_LISTS; i++) begin
			cnt_nxt[i] = cnt_eff[i];
			if (dest == DST_UP_TIME) begin
				if (4'(i) == UP_RING_T_CNT && up_ring_ok) begin
					cnt_nxt[i] = cnt_eff[i] + 1'b1;
				end
				if (4'(i) == UP_SECTOR_T_CNT && up_sect_ok) begin
					cnt_nxt[i] = cnt_eff[i] + 1'b1;
				end
			end else if (dest != DST_DROP && 4'(i) == dest) begin
				cnt_nxt[i] = cnt_eff[i] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LISTS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (valid_s1 && adv_s1) begin
			cnt_q <= cnt_nxt;
		end
	end

	// ------------------------------------------------------ result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			dest_s2  <= dest;
			slot_s2  <= slot;
			chan_s2  <= dch;
			value_s2 <= (dest != DST_DROP) ? val_s1 : '0;
		end
	end

	assign res_valid        = valid_s2;
	assign destination      = dest_s2;
	assign slot_index       = slot_s2;
	assign detector_channel = chan_s2;
	assign passed_value     = value_s2;

	// ----------------------------------------------------------- assertions
	`DHR_ASSERT(a_stall_needs_word, hit_stall |-> valid_s1 && valid_s2 && res_stall, "hit_stall without a held word")
	`DHR_ASSERT(a_drop_is_zero, valid_s2 && dest_s2 == DST_DROP |-> slot_s2 == '0 && chan_s2 == '0 && value_s2 == '0, "dropped word carries data")
	`DHR_ASSERT(a_slot_below_cap, valid_s2 && dest_s2 != DST_DROP && dest_s2 != DST_UP_TIME |-> CNT_W'(slot_s2) < cap_of(dest_s2), "slot beyond list capacity")
	`DHR_ASSERT(a_up_time_bound, cnt_q[UP_RING_T_CNT] <= CNT_W'(RING_SLOTS) && cnt_q[UP_SECTOR_T_CNT] <= CNT_W'(SECTOR_SLOTS), "upstream time count overran")

endmodule

`default_nettype wire
